@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// cond at one edge forces expr at the next edge
`define ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

@@ hdl/rrqs_pkg.sv @@
`default_nettype none

package rrqs_pkg;

	localparam int TASK_W    = 4;
	localparam int QUANTUM_W = 10;

	localparam logic [TASK_W-1:0]    IDLE_TASK_RST    = 4'd0;
	localparam logic [QUANTUM_W-1:0] IDLE_QUANTUM_RST = 10'd10;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_ADD  = 1'b1;

	localparam logic CFG_IDLE_TASK    = 1'b0;
	localparam logic CFG_IDLE_QUANTUM = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_QRD
	} rrqs_state_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [TASK_W-1:0] slot;
	} rrqs_fifo_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} rrqs_fifo_sts_t;

endpackage

`default_nettype wire

@@ hdl/rrqs_ready_fifo.sv @@
`default_nettype none

`include "assert_macros.svh"

module rrqs_ready_fifo #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire rrqs_pkg::rrqs_fifo_req_t req,
	output rrqs_pkg::rrqs_fifo_sts_t    sts,
	output logic [rrqs_pkg::TASK_W-1:0] rd_slot
);

	import rrqs_pkg::*;

	localparam int PTR_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	logic [TASK_W-1:0] mem [MAX_TASKS];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(MAX_TASKS - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CNT_W'(MAX_TASKS));

	// read-first: a pop and a push on the same entry return the old slot
	always_ff @(posedge clk) begin
		if (req.pop) begin
			rd_slot <= mem[head_q];
		end
		if (req.push) begin
			mem[tail_q] <= req.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (req.pop) begin
				head_q <= wrap_next(head_q);
			end
			if (req.push) begin
				tail_q <= wrap_next(tail_q);
			end
			if (req.push && !req.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (req.pop && !req.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_CLK(a_no_underflow, req.pop |-> !sts.empty, "pop from empty ready queue")
	`ASSERT_CLK(a_no_overflow, (req.push && !req.pop) |-> !sts.full, "push into full ready queue")
	`ASSERT_CLK(a_count_range, count_q <= CNT_W'(MAX_TASKS), "ready queue count out of range")

endmodule

`default_nettype wire

@@ hdl/rrqs_quantum_mem.sv @@
`default_nettype none

module rrqs_quantum_mem #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [$clog2(MAX_TASKS)-1:0]     wr_addr,
	input  wire logic [rrqs_pkg::QUANTUM_W-1:0]   wr_data,
	input  wire logic                             rd_en,
	input  wire logic [$clog2(MAX_TASKS)-1:0]     rd_addr,
	output logic [rrqs_pkg::QUANTUM_W-1:0]        rd_data
);

	import rrqs_pkg::*;

	logic [QUANTUM_W-1:0] mem [MAX_TASKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/round_robin_quantum_scheduler_core.sv @@
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | tuser: req_type; tdata: task_id, task_quantum
// m       | out | m_tvalid/m_tready  | tdata: running_task, switched, overflow
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Add and non-rescheduling tick: result registered at the accept edge.
// Reschedule tick: quantum table read (S_QRD), or when the head of the ready queue is
// popped, queue read (S_POP) then quantum table read; idle slot skips the table.
// s_tready is low while a reschedule is in flight or a result waits without m_tready.
// arst_n clears pointers, running task and quantum to their reset values; no memory sweep.
`default_nettype none

`include "assert_macros.svh"

module round_robin_quantum_scheduler_core #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [3:0] task_id, [13:4] task_quantum, [15:14] zero
	input  wire logic [0:0]  s_tuser,   // [0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [3:0] running_task, [4] switched, [5] overflow, [7:6] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data
);

	import rrqs_pkg::*;

	localparam int IDX_W = $clog2(MAX_TASKS);

	rrqs_state_t state_q, state_d;

	logic [TASK_W-1:0]    cur_q;
	logic [TASK_W-1:0]    nxt_q;
	logic [QUANTUM_W-1:0] rem_q;
	logic [TASK_W-1:0]    idle_id_q;
	logic [QUANTUM_W-1:0] idle_qnt_q;
	logic                 m_tvalid_q;
	logic [5:0]           m_data_q;

	logic                 req_type;
	logic [TASK_W-1:0]    task_id;
	logic [QUANTUM_W-1:0] task_quantum;
	logic                 accept;

	rrqs_fifo_req_t       fifo_req;
	rrqs_fifo_sts_t       fifo_sts;
	logic [TASK_W-1:0]    fifo_slot;

	logic                 qm_we;
	logic                 qm_re;
	logic [TASK_W-1:0]    qm_rd_slot;
	logic [QUANTUM_W-1:0] qm_rd_data;

	logic [QUANTUM_W-1:0] rem_dec;
	logic                 resched;
	logic                 requeue;
	logic                 add_bad;

	logic                 res_valid;
	logic [TASK_W-1:0]    res_task;
	logic                 res_sw;
	logic                 res_ovf;
	logic                 cur_ld;
	logic [TASK_W-1:0]    cur_d;
	logic                 rem_ld;
	logic [QUANTUM_W-1:0] rem_d;
	logic                 nxt_ld;
	logic [TASK_W-1:0]    nxt_d;

	function automatic logic [IDX_W-1:0] slot_idx(input logic [TASK_W-1:0] slot);
		logic [7:0] ext;
		ext = {4'b0, slot};
		return ext[IDX_W-1:0];
	endfunction

	assign req_type     = s_tuser[0];
	assign task_id      = s_tdata[3:0];
	assign task_quantum = s_tdata[13:4];

	assign s_tready  = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {2'b00, m_data_q};

	assign rem_dec = (rem_q != '0) ? rem_q - QUANTUM_W'(1) : '0;
	assign resched = (rem_dec == '0) || fifo_sts.empty;
	assign requeue = (cur_q != idle_id_q);
	assign add_bad = fifo_sts.full || (32'(task_id) >= MAX_TASKS);

	rrqs_ready_fifo #(
		.MAX_TASKS(MAX_TASKS)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fifo_req),
		.sts    (fifo_sts),
		.rd_slot(fifo_slot)
	);

	rrqs_quantum_mem #(
		.MAX_TASKS(MAX_TASKS)
	) u_qmem (
		.clk    (clk),
		.wr_en  (qm_we),
		.wr_addr(slot_idx(task_id)),
		.wr_data(task_quantum),
		.rd_en  (qm_re),
		.rd_addr(slot_idx(qm_rd_slot)),
		.rd_data(qm_rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req_type == REQ_TICK && resched) begin
					if (!fifo_sts.empty) begin
						state_d = S_POP;
					end else if (requeue) begin
						state_d = S_QRD;
					end
				end
			end
			S_POP: begin
				if (fifo_slot != idle_id_q) begin
					state_d = S_QRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_QRD:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		fifo_req   = '0;
		qm_we      = 1'b0;
		qm_re      = 1'b0;
		qm_rd_slot = cur_q;
		res_valid  = 1'b0;
		res_task   = cur_q;
		res_sw     = 1'b0;
		res_ovf    = 1'b0;
		cur_ld     = 1'b0;
		cur_d      = cur_q;
		rem_ld     = 1'b0;
		rem_d      = rem_dec;
		nxt_ld     = 1'b0;
		nxt_d      = cur_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_ADD) begin
						res_valid     = 1'b1;
						res_ovf       = add_bad;
						qm_we         = !add_bad;
						fifo_req.push = !add_bad;
						fifo_req.slot = task_id;
					end else if (!resched) begin
						res_valid = 1'b1;
						rem_ld    = 1'b1;
					end else if (!fifo_sts.empty) begin
						fifo_req.pop  = 1'b1;
						fifo_req.push = requeue;
						fifo_req.slot = cur_q;
					end else if (requeue) begin
						qm_re  = 1'b1;
						nxt_ld = 1'b1;
					end else begin
						res_valid = 1'b1;
						rem_ld    = 1'b1;
						rem_d     = idle_qnt_q;
					end
				end
			end
			S_POP: begin
				nxt_ld     = 1'b1;
				nxt_d      = fifo_slot;
				qm_rd_slot = fifo_slot;
				if (fifo_slot != idle_id_q) begin
					qm_re = 1'b1;
				end else begin
					res_valid = 1'b1;
					res_task  = fifo_slot;
					res_sw    = (fifo_slot != cur_q);
					cur_ld    = 1'b1;
					cur_d     = fifo_slot;
					rem_ld    = 1'b1;
					rem_d     = idle_qnt_q;
				end
			end
			S_QRD: begin
				res_valid = 1'b1;
				res_task  = nxt_q;
				res_sw    = (nxt_q != cur_q);
				cur_ld    = 1'b1;
				cur_d     = nxt_q;
				rem_ld    = 1'b1;
				rem_d     = qm_rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= IDLE_TASK_RST;
			rem_q      <= IDLE_QUANTUM_RST;
			idle_id_q  <= IDLE_TASK_RST;
			idle_qnt_q <= IDLE_QUANTUM_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cur_ld) begin
				cur_q <= cur_d;
			end
			if (rem_ld) begin
				rem_q <= rem_d;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IDLE_TASK:    idle_id_q  <= cfg_data[TASK_W-1:0];
					CFG_IDLE_QUANTUM: idle_qnt_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (res_valid) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (nxt_ld) begin
			nxt_q <= nxt_d;
		end
		if (res_valid) begin
			m_data_q <= {res_ovf, res_sw, res_task};
		end
	end

	`ASSERT_CLK(a_result_slot_free, res_valid |-> (!m_tvalid_q || m_tready), "result overwrites pending transaction")
	`ASSERT_NEXT(a_qrd_finishes, state_q == S_QRD, state_q == S_IDLE, "quantum read did not finish")
	`ASSERT_CLK(a_busy_no_accept, (state_q != S_IDLE) |-> !s_tready, "transaction taken mid reschedule")

endmodule

`default_nettype wire

@@ tb/round_robin_quantum_scheduler_core_tb.sv @@
`default_nettype none

module round_robin_quantum_scheduler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrqs_pkg::*;

	localparam int SLOTS       = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [3:0] running;
		logic       switched;
		logic       overflow;
	} sched_result_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] slot;
		logic [9:0] quantum;
		logic       typed;
		logic [3:0] want_run;
		logic       want_sw;
		logic       want_ovf;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [9:0]  cfg_data  = '0;

	// scheduler state as predicted
	logic [3:0]  rq_mem [SLOTS];
	logic [9:0]  qtab [SLOTS];
	logic [3:0]  rq_head    = '0;
	logic [3:0]  rq_tail    = '0;
	logic [4:0]  rq_count   = '0;
	logic [3:0]  cur_slot   = IDLE_TASK_RST;
	logic [10:0] ticks_left = {1'b0, IDLE_QUANTUM_RST};
	logic [3:0]  idle_slot  = IDLE_TASK_RST;
	logic [9:0]  idle_ticks = IDLE_QUANTUM_RST;

	sched_result_t outcome_q [$];
	sched_result_t want;
	int            pending  = 0;
	int            n_fail   = 0;
	logic          hold_req = 1'b0;
	logic          steady   = 1'b0;

	localparam logic [3:0] PH_IDLE  [PHASES] = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd3, 4'd0, 4'd6, 4'd0};
	localparam logic [9:0] PH_QUANT [PHASES] = '{10'd2, 10'd0, 10'd1, 10'd3, 10'd1, 10'd5,
		10'd0, 10'd1023};

	stim_row_t dir_rows [26] = '{
		'{REQ_TICK, 4'd0,  10'd0,    1'b1, 4'd0, 1'b0, 1'b0},
		'{REQ_ADD,  4'd3,  10'd2,    1'b1, 4'd0, 1'b0, 1'b0},
		'{REQ_TICK, 4'd0,  10'd0,    1'b0, 4'd0, 1'b0, 1'b0},
		'{REQ_TICK, 4'd0,  10'd0,    1'b0, 4'd0, 1'b0, 1'b0},
		'{REQ_ADD,  4'd1,  10'd0,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd2,  10'd1,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd0,  10'd5,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd4,  10'd2,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd5,  10'd1,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd6,  10'd3,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd7,  10'd2,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd8,  10'd1,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd9,  10'd4,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd10, 10'd2,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd11, 10'd3,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd12, 10'd1,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd13, 10'd2,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd14, 10'd4,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd15, 10'd3,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd3,  10'd3,    1'b1, 4'd3, 1'b0, 1'b0},
		'{REQ_ADD,  4'd15, 10'd1023, 1'b1, 4'd3, 1'b0, 1'b1},
		'{REQ_TICK, 4'd0,  10'd0,    1'b0, 4'd0, 1'b0, 1'b0},
		'{REQ_TICK, 4'd0,  10'd0,    1'b0, 4'd0, 1'b0, 1'b0},
		'{REQ_TICK, 4'd0,  10'd0,    1'b0, 4'd0, 1'b0, 1'b0},
		'{REQ_TICK, 4'd0,  10'd0,    1'b0, 4'd0, 1'b0, 1'b0},
		'{REQ_TICK, 4'd0,  10'd0,    1'b0, 4'd0, 1'b0, 1'b0}
	};

	round_robin_quantum_scheduler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic next_schedule(input logic kind, input logic [3:0] slot,
		input logic [9:0] quantum, output sched_result_t res);
		logic [3:0] nxt;
		logic       requeue;
		res = '{running: cur_slot, switched: 1'b0, overflow: 1'b0};
		if (kind == REQ_ADD) begin
			if (rq_count >= SLOTS) begin
				res.overflow = 1'b1;
			end else begin
				qtab[slot]      = quantum;
				rq_mem[rq_tail] = slot;
				rq_tail         = rq_tail + 1'b1;
				rq_count        = rq_count + 1'b1;
			end
		end else begin
			if (ticks_left != 0)
				ticks_left = ticks_left - 1'b1;
			if (ticks_left == 0 || rq_count == 0) begin
				requeue = (cur_slot != idle_slot);
				if (rq_count > 0) begin
					nxt      = rq_mem[rq_head];
					rq_head  = rq_head + 1'b1;
					rq_count = rq_count - 1'b1;
					if (requeue) begin
						rq_mem[rq_tail] = cur_slot;
						rq_tail         = rq_tail + 1'b1;
						rq_count        = rq_count + 1'b1;
					end
				end else begin
					nxt = requeue ? cur_slot : idle_slot;
				end
				ticks_left   = {1'b0, (nxt == idle_slot) ? idle_ticks : qtab[nxt]};
				res.switched = (nxt != cur_slot);
				cur_slot     = nxt;
				res.running  = nxt;
			end
		end
	endtask

	task automatic issue_request(input logic kind, input logic [3:0] slot,
		input logic [9:0] quantum, input logic typed, input sched_result_t typed_res);
		sched_result_t res;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, quantum, slot};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		next_schedule(kind, slot, quantum, res);
		outcome_q.push_back(typed ? typed_res : res);
		pending++;
	endtask

	task automatic write_sched_cfg(input logic [3:0] slot, input logic [9:0] quantum);
		logic [5:0] pad;
		pad = 6'($urandom_range(0, 63));
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDLE_TASK;
		cfg_data  <= {pad, slot};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		idle_slot = slot;
		cfg_index <= CFG_IDLE_QUANTUM;
		cfg_data  <= quantum;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		idle_ticks = quantum;
		cfg_valid <= 1'b0;
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (80)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (outcome_q.size() == 0) begin
				$error("unexpected result transaction: m_tdata %h", m_tdata);
				n_fail++;
			end else begin
				want = outcome_q.pop_front();
				pending--;
				if (m_tdata[3:0] !== want.running) begin
					$error("running_task: expected %0d, got %0d", want.running, m_tdata[3:0]);
					n_fail++;
				end
				if (m_tdata[4] !== want.switched) begin
					$error("switched: expected %0b, got %0b", want.switched, m_tdata[4]);
					n_fail++;
				end
				if (m_tdata[5] !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, m_tdata[5]);
					n_fail++;
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic       kind;
		logic [3:0] slot;
		logic [9:0] quantum;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle quantum of one so the directed sequence switches early
		write_sched_cfg(IDLE_TASK_RST, 10'd1);
		foreach (dir_rows[i])
			issue_request(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].quantum,
				dir_rows[i].typed, '{running: dir_rows[i].want_run,
				switched: dir_rows[i].want_sw, overflow: dir_rows[i].want_ovf});
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			write_sched_cfg(PH_IDLE[p], PH_QUANT[p]);
			steady = (p == 4);
			if (p == 1)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				if (!steady && $urandom_range(0, 99) < 16) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 5))
						@(posedge clk);
				end
				slot    = 4'($urandom_range(0, 15));
				quantum = 10'($urandom_range(0, 1023));
				kind    = REQ_TICK;
				if (rq_count >= SLOTS) begin
					if ($urandom_range(0, 9) == 0)
						kind = REQ_ADD;
				end else if ($urandom_range(0, 2) == 0) begin
					kind = REQ_ADD;
					if ($urandom_range(0, 3) == 0)
						slot = idle_slot;
					quantum = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(5, 40))
						: 10'($urandom_range(0, 4));
				end
				issue_request(kind, slot, quantum, 1'b0, '0);
			end
			s_tvalid <= 1'b0;
			wait (pending == 0);
			@(posedge clk);
		end

		repeat (10)
			@(posedge clk);
		if (n_fail == 0 && outcome_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
